>>> rtl/glbdf_pkg.sv
// Shared types and constants for the GLB chunk deframer.
// Used by glbdf_parser, glbdf_outq and glb_chunk_deframer; no dependencies.
`timescale 1ns / 1ps

package glbdf_pkg;

  // Container constants (little-endian words as they appear after shifting in)
  localparam logic [31:0] GlbMagic    = 32'h4654_6C67;
  localparam logic [31:0] TypeJson    = 32'h4E4F_534A;
  localparam logic [31:0] TypeBin     = 32'h004E_4942;
  localparam logic [3:0]  HeaderBytes = 4'd12;

  // Result item kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  // Channel tags
  localparam logic ChanJson = 1'b0;
  localparam logic ChanBin  = 1'b1;

  // Final status codes
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTooShort = 2'd1,
    StBadMagic = 2'd2,
    StNoJson   = 2'd3
  } status_e;

  // Parser phases
  typedef enum logic [2:0] {
    PhHeader   = 3'd0,
    PhChunkHdr = 3'd1,
    PhPayload  = 3'd2,
    PhPad      = 3'd3,
    PhIgnore   = 3'd4
  } phase_e;

  // Input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  // Result item
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       channel;
    logic       chunk_first;
    logic       chunk_final;
    logic [1:0] status;
    logic       dropped_tail;
    logic       last;
  } out_t;

  // Results of one parsed byte, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;    // number of valid items (0..2)
    out_t       item0;  // written first
    out_t       item1;  // only when cnt == 2
  } push_t;

endpackage

>>> rtl/glbdf_parser.sv
// Byte-at-a-time GLB container parser: header check, chunk walk, status.
// Depends on glbdf_pkg. Produces up to two result items per stepped byte.
`timescale 1ns / 1ps

module glbdf_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  glbdf_pkg::in_t    in_i,
  output glbdf_pkg::push_t  push_o
);

  // Control state
  glbdf_pkg::phase_e phase_q, phase_d;
  logic [3:0]        bpos_q, bpos_d;
  logic [1:0]        pad_q, pad_d;
  logic              json_seen_q, json_seen_d;
  logic              bad_magic_q, bad_magic_d;

  // Datapath state
  logic [31:0] magic_q, magic_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] rem_q, rem_d;

  logic [7:0]  b;
  logic [3:0]  bpos_inc;
  logic [2:0]  hdr_pos;
  logic        pay_vld;
  logic        first;
  logic        fin;
  logic        kept;
  logic        kept_d;

  glbdf_pkg::out_t pay_item;
  glbdf_pkg::out_t stat_item;

  assign b        = in_i.data_byte;
  assign bpos_inc = bpos_q + 4'd1;
  assign hdr_pos  = bpos_q[2:0];
  assign kept     = (type_q == glbdf_pkg::TypeJson) || (type_q == glbdf_pkg::TypeBin);
  // type as it stands after this byte; the last header byte completes it
  assign kept_d   = (type_d == glbdf_pkg::TypeJson) || (type_d == glbdf_pkg::TypeBin);
  assign first    = (rem_q == len_q);
  assign fin      = (rem_d == 32'd0);

  // Next state for one byte
  always_comb begin
    phase_d     = phase_q;
    bpos_d      = bpos_q;
    pad_d       = pad_q;
    json_seen_d = json_seen_q;
    bad_magic_d = bad_magic_q;
    magic_d     = magic_q;
    len_d       = len_q;
    type_d      = type_q;
    rem_d       = rem_q;
    pay_vld     = 1'b0;
    unique case (phase_q)
      glbdf_pkg::PhHeader: begin
        if (bpos_q < 4'd4) begin
          magic_d = {b, magic_q[31:8]};
        end
        bpos_d = bpos_inc;
        if (bpos_inc >= glbdf_pkg::HeaderBytes) begin
          bpos_d = 4'd0;
          if (magic_d != glbdf_pkg::GlbMagic) begin
            bad_magic_d = 1'b1;
            phase_d     = glbdf_pkg::PhIgnore;
          end else begin
            phase_d = glbdf_pkg::PhChunkHdr;
          end
        end
      end
      glbdf_pkg::PhChunkHdr: begin
        if (!hdr_pos[2]) begin
          len_d = {b, len_q[31:8]};
        end else begin
          type_d = {b, type_q[31:8]};
        end
        bpos_d = bpos_inc;
        if (hdr_pos == 3'd7) begin
          // length is complete; padding rounds up to a four-byte boundary
          rem_d = len_q;
          pad_d = 2'd0 - len_q[1:0];
          if (len_q == 32'd0) begin
            if (type_d == glbdf_pkg::TypeJson) begin
              json_seen_d = 1'b1;
            end
            phase_d = (pad_d != 2'd0) ? glbdf_pkg::PhPad : glbdf_pkg::PhChunkHdr;
            bpos_d  = 4'd0;
          end else begin
            phase_d = glbdf_pkg::PhPayload;
            bpos_d  = 4'd0;
          end
        end
      end
      glbdf_pkg::PhPayload: begin
        rem_d   = rem_q - 32'd1;
        pay_vld = kept;
        if (rem_d == 32'd0) begin
          if (type_q == glbdf_pkg::TypeJson) begin
            json_seen_d = 1'b1;
          end
          phase_d = (pad_q != 2'd0) ? glbdf_pkg::PhPad : glbdf_pkg::PhChunkHdr;
          bpos_d  = 4'd0;
        end
      end
      glbdf_pkg::PhPad: begin
        pad_d = pad_q - 2'd1;
        if (pad_d == 2'd0) begin
          phase_d = glbdf_pkg::PhChunkHdr;
          bpos_d  = 4'd0;
        end
      end
      default: begin
        // bad magic or unused code: ignore until end of file
      end
    endcase
  end

  // Result items for this byte
  always_comb begin
    pay_item              = '0;
    pay_item.kind         = glbdf_pkg::KindPayload;
    pay_item.payload_byte = b;
    pay_item.channel      = (type_q == glbdf_pkg::TypeBin) ? glbdf_pkg::ChanBin
                                                           : glbdf_pkg::ChanJson;
    pay_item.chunk_first  = first;
    pay_item.chunk_final  = fin;

    stat_item      = '0;
    stat_item.kind = glbdf_pkg::KindStatus;
    stat_item.last = 1'b1;
    priority if (phase_d == glbdf_pkg::PhHeader) begin
      stat_item.status = glbdf_pkg::StTooShort;
    end else if (bad_magic_d) begin
      stat_item.status = glbdf_pkg::StBadMagic;
    end else if (!json_seen_d) begin
      stat_item.status = glbdf_pkg::StNoJson;
    end else begin
      stat_item.status = glbdf_pkg::StOk;
    end
    stat_item.dropped_tail = (phase_d == glbdf_pkg::PhPayload) && (rem_d != 32'd0) && kept_d;

    push_o.item0 = pay_vld ? pay_item : stat_item;
    push_o.item1 = stat_item;
    if (step_i) begin
      push_o.cnt = {1'b0, pay_vld} + {1'b0, in_i.end_of_file};
    end else begin
      push_o.cnt = 2'd0;
    end
  end

  // Control registers; end of file returns to the start of a new file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= glbdf_pkg::PhHeader;
      bpos_q      <= 4'd0;
      pad_q       <= 2'd0;
      json_seen_q <= 1'b0;
      bad_magic_q <= 1'b0;
    end else if (step_i) begin
      if (in_i.end_of_file) begin
        phase_q     <= glbdf_pkg::PhHeader;
        bpos_q      <= 4'd0;
        pad_q       <= 2'd0;
        json_seen_q <= 1'b0;
        bad_magic_q <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        bpos_q      <= bpos_d;
        pad_q       <= pad_d;
        json_seen_q <= json_seen_d;
        bad_magic_q <= bad_magic_d;
      end
    end
  end

  // Word registers; each is fully loaded before it is used
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      magic_q <= magic_d;
      len_q   <= len_d;
      type_q  <= type_d;
      rem_q   <= rem_d;
    end
  end

endmodule

>>> rtl/glbdf_outq.sv
// Four-entry result queue: takes up to two items a cycle, gives one.
// Depends on glbdf_pkg.
`timescale 1ns / 1ps

module glbdf_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  glbdf_pkg::push_t  push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output glbdf_pkg::out_t   out_data_o
);

  glbdf_pkg::out_t mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] wr_nxt;
  logic       pop;

  assign wr_nxt      = wr_q + 2'd1;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_q];
  // a byte can add two items
  assign room_o      = (cnt_q <= 3'd2);

  // Pointer and level update
  always_comb begin
    wr_d  = wr_q + push_i.cnt;
    rd_d  = pop ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {1'b0, push_i.cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.item0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.item1;
    end
  end

endmodule

>>> rtl/glb_chunk_deframer.sv
// Top level of the GLB chunk deframer: input register, parser, result queue.
// Depends on glbdf_pkg, glbdf_parser and glbdf_outq.
`timescale 1ns / 1ps

// Streams a binary glTF file in one byte per clock and passes out the payload
// bytes of JSON and BIN chunks, tagged with channel and first/final marks,
// followed by one status item on the end-of-file byte. Each request is held
// in an input register and parsed once the queue has room; its results are
// written to a four-entry result queue whose head drives the output, so the
// first result passes through the input register and a queue entry before it
// is presented. One byte is accepted every clock; the input stalls only
// while fewer than two queue entries are free, which happens when the output
// is stalled or when an end-of-file byte that yields both a payload item and
// the status item arrives while two items already wait in the queue.
module glb_chunk_deframer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  glbdf_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output glbdf_pkg::out_t  out_data_o
);

  logic             in_vld_q, in_vld_d;
  glbdf_pkg::in_t   in_q;
  logic             room;
  logic             step;
  logic             accept;
  glbdf_pkg::push_t push;

  assign step       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register
  always_comb begin
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  glbdf_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_q),
    .push_o (push)
  );

  glbdf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Checks
  a_push_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> step)
    else $error("results pushed without a parsed byte");

  a_two_needs_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (in_q.end_of_file && push.item1.last))
    else $error("two results without end of file");

  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == out_data_o.kind))
    else $error("last mark does not match item kind");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == glbdf_pkg::KindPayload)) |->
      ((out_data_o.status == glbdf_pkg::StOk) && !out_data_o.dropped_tail))
    else $error("payload item carries status bits");

endmodule

>>> tb/glb_chunk_deframer_test.sv
// Self-checking testbench for glb_chunk_deframer: streams whole GLB files,
// well-formed and broken, and checks every payload and status item in order.
// Depends on glbdf_pkg and the glb_chunk_deframer RTL.
`timescale 1ns / 1ps

module glb_chunk_deframer_test;
  import glbdf_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Predicts the result items of the deframer and checks them as they come out
  class chunk_scoreboard;
    out_t        expected_q[$];
    int          errors;
    int          n_payload;
    int          n_status;
    phase_e      phase;
    logic [3:0]  pos;
    logic [31:0] magic;
    logic [31:0] len_w;
    logic [31:0] type_w;
    logic [31:0] remain;
    logic [1:0]  pad;
    bit          json_seen;
    logic [1:0]  err;

    function new();
      errors    = 0;
      n_payload = 0;
      n_status  = 0;
      clear();
    endfunction

    function void clear();
      phase     = PhHeader;
      pos       = '0;
      magic     = '0;
      len_w     = '0;
      type_w    = '0;
      remain    = '0;
      pad       = '0;
      json_seen = 1'b0;
      err       = '0;
    endfunction

    function bit kept();
      return type_w == TypeJson || type_w == TypeBin;
    endfunction

    function void close_chunk();
      phase = (pad != 2'd0) ? PhPad : PhChunkHdr;
      pos   = '0;
    endfunction

    // Walk one accepted request through the container state
    function void note_request(in_t req);
      out_t       item;
      logic [7:0] b;
      logic [2:0] p;
      bit         first;
      bit         fin;
      status_e    st;
      b = req.data_byte;
      case (phase)
        PhHeader: begin
          if (pos < 4) magic = {b, magic[31:8]};
          pos = pos + 4'd1;
          if (pos >= HeaderBytes) begin
            pos = '0;
            if (magic != GlbMagic) begin
              err   = StBadMagic;
              phase = PhIgnore;
            end else begin
              phase = PhChunkHdr;
            end
          end
        end
        PhChunkHdr: begin
          p = pos[2:0];
          if (p < 4) len_w = {b, len_w[31:8]};
          else type_w = {b, type_w[31:8]};
          pos = pos + 4'd1;
          if (p == 3'd7) begin
            remain = len_w;
            pad    = 2'd0 - len_w[1:0];
            if (len_w == 32'd0) begin
              if (type_w == TypeJson) json_seen = 1'b1;
              close_chunk();
            end else begin
              phase = PhPayload;
              pos   = '0;
            end
          end
        end
        PhPayload: begin
          first  = (remain == len_w);
          remain = remain - 32'd1;
          fin    = (remain == 32'd0);
          if (kept()) begin
            item              = '0;
            item.kind         = KindPayload;
            item.payload_byte = b;
            item.channel      = (type_w == TypeBin) ? ChanBin : ChanJson;
            item.chunk_first  = first;
            item.chunk_final  = fin;
            expected_q.push_back(item);
          end
          if (fin) begin
            if (type_w == TypeJson) json_seen = 1'b1;
            close_chunk();
          end
        end
        PhPad: begin
          pad = pad - 2'd1;
          if (pad == 2'd0) begin
            phase = PhChunkHdr;
            pos   = '0;
          end
        end
        default: ;  // ignore until end of file
      endcase

      // End of file: status item, then back to the reset state
      if (req.end_of_file) begin
        if (phase == PhHeader) st = StTooShort;
        else if (err == StBadMagic) st = StBadMagic;
        else if (!json_seen) st = StNoJson;
        else st = StOk;
        item              = '0;
        item.kind         = KindStatus;
        item.status       = st;
        item.dropped_tail = (phase == PhPayload) && (remain != 32'd0) && kept();
        item.last         = 1'b1;
        expected_q.push_back(item);
        clear();
      end
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.kind == KindStatus) n_status++;
      else n_payload++;
      field_check("kind", want.kind, got.kind);
      field_check("payload_byte", want.payload_byte, got.payload_byte);
      field_check("channel", want.channel, got.channel);
      field_check("chunk_first", want.chunk_first, got.chunk_first);
      field_check("chunk_final", want.chunk_final, got.chunk_final);
      field_check("status", want.status, got.status);
      field_check("dropped_tail", want.dropped_tail, got.dropped_tail);
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  chunk_scoreboard sb = new();
  int  sent_bytes = 0;
  int  sent_files = 0;
  bit  idle_on = 1'b1;
  int  stall_left = 0;

  glb_chunk_deframer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls in bursts, started at random while idle_on is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Send one byte, with an occasional gap before it
  task automatic send_request(input logic [7:0] b, input bit eof);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap      = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              = 1'b1;
    in_data.data_byte     = b;
    in_data.end_of_file   = eof;
    do @(posedge clk); while (in_stall);
    sb.note_request(in_data);
    sent_bytes++;
  endtask

  task automatic send_file(input byte_q_t f);
    foreach (f[i]) send_request(f[i], i == f.size() - 1);
    sent_files++;
  endtask

  // Hold the sender until every expected result is out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic void push_word(ref byte_q_t f, input logic [31:0] w);
    for (int k = 0; k < 4; k++) f.push_back(w[8*k +: 8]);
  endfunction

  // Mostly JSON and BIN, some unknown types and near misses
  function automatic logic [31:0] chunk_type();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) return TypeJson;
    if (sel <= 6) return TypeBin;
    if (sel == 7) return TypeJson ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  // Build one file: mostly well-formed chunks, some short, bad or cut off
  function automatic byte_q_t random_file();
    byte_q_t     f;
    int          mode;
    int          n;
    int          cut;
    logic [31:0] word;
    logic [31:0] len;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      n = $urandom_range(1, 11);
      for (int i = 0; i < n; i++)
        f.push_back((i < 4 && $urandom_range(0, 1)) ? GlbMagic[8*i +: 8] : 8'($urandom));
      return f;
    end
    word = GlbMagic;
    if (mode == 1) word ^= 32'd1 << $urandom_range(0, 31);
    else if (mode == 2) word = $urandom;
    push_word(f, word);
    push_word(f, $urandom);
    push_word(f, $urandom);
    if (mode <= 2) begin
      n = $urandom_range(0, 8);
      repeat (n) f.push_back(8'($urandom));
      return f;
    end
    n = $urandom_range(0, 3);
    repeat (n) begin
      len = $urandom_range(0, 9);
      push_word(f, len);
      push_word(f, chunk_type());
      repeat (len) f.push_back(8'($urandom));
      repeat ((4 - len[1:0]) & 3) f.push_back(8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) begin
      // huge length: the file ends inside the payload
      len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h0000_0100);
      push_word(f, len);
      push_word(f, chunk_type());
      n = $urandom_range(0, 20);
      repeat (n) f.push_back(8'($urandom));
    end else if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, f.size());
      f   = f[0:cut-1];
    end
    return f;
  endfunction

  initial begin
    byte_q_t f;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // One-byte file, eleven header bytes with good magic, full header with bad magic
    f = '{8'hFF};
    send_file(f);
    f = '{8'h67, 8'h6C, 8'h54, 8'h46, 8'h02, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00};
    send_file(f);
    f = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'hFF};
    send_file(f);
    drain();

    // Random files; the tail of the run goes without gaps or stalls
    while (sent_bytes < 950) begin
      idle_on = (sent_bytes < 780);
      f = random_file();
      send_file(f);
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (10) @(posedge clk);

    $display("Streamed %0d files (%0d bytes); checked %0d payload and %0d status items.",
             sent_files, sent_bytes, sb.n_payload, sb.n_status);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
rtl/glbdf_pkg.sv
rtl/glbdf_parser.sv
rtl/glbdf_outq.sv
rtl/glb_chunk_deframer.sv
tb/glb_chunk_deframer_test.sv
